// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point projector checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define PPD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define PPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared formats, register codes, types and saturation helpers of the
// point projector.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

  localparam int PT_W       = 24;  // point coordinates, Q16.8
  localparam int ROT_W      = 16;  // rotation entries, Q2.14
  localparam int TR_W       = 21;  // translation entries, Q17.4
  localparam int TR_SHIFT   = 18;  // Q17.4 to 22 fractional bits
  localparam int K_W        = 20;  // distortion coefficients, Q4.16
  localparam int KF_W       = 16;  // coefficient fraction bits
  localparam int F_W        = 24;  // focal lengths and principal point
  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ROW_W      = 48;
  localparam int TRN_W      = 63;
  localparam int RADC_W     = 60;
  localparam int TANC_W     = 40;
  localparam int CAM_W      = 43;  // camera-frame coordinate, 22 fraction bits
  localparam int Q_W        = 32;  // normalized values, Q7.24
  localparam int QMAG_W     = 31;  // quotient magnitude
  localparam int FRAC_W     = 24;
  localparam int INT_W      = QMAG_W - FRAC_W;
  localparam int ACC_W      = 72;  // wide headroom for clamping
  localparam int PROD_W     = 2 * Q_W;
  localparam int KP_W       = K_W + Q_W;
  localparam int TG_W       = KP_W + 2;
  localparam int TS_W       = TG_W - KF_W;
  localparam int FP_W       = F_W + 1 + Q_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT0, REG_ROT1, REG_ROT2, REG_TRANS,
    REG_RADIAL, REG_TANGENT, REG_FOCAL, REG_PPOINT
  } ppd_reg_t;

  localparam logic [ROW_W-1:0] ROT0_RST  = 48'd16384;
  localparam logic [ROW_W-1:0] ROT1_RST  = 48'd1073741824;
  localparam logic [ROW_W-1:0] ROT2_RST  = 48'd70368744177664;
  localparam logic [ROW_W-1:0] FOCAL_RST = 48'd4294967552;

  localparam logic signed [ACC_W-1:0] NORM_ONE = 72'sd16777216;
  localparam logic signed [ACC_W-1:0] S32_MAX  = 72'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN  = -72'sd2147483648;
  localparam logic signed [ACC_W-1:0] S24_MAX  = 72'sd8388607;
  localparam logic signed [ACC_W-1:0] S24_MIN  = -72'sd8388608;

  typedef struct packed {
    logic                    ovf;
    logic signed [Q_W-1:0]   val;
  } ppd_sat32_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [PIX_W-1:0] val;
  } ppd_sat24_t;

  typedef struct packed {
    logic             vld;
    logic             zero;
    logic             negx;
    logic             negy;
    logic [CAM_W-1:0] anx;
    logic [CAM_W-1:0] any;
    logic [CAM_W-1:0] ad;
  } ppd_div_in_t;

  typedef struct packed {
    logic zero;
    logic negx;
    logic negy;
    logic ovfx;
    logic ovfy;
  } ppd_div_side_t;

  typedef struct packed {
    logic                  vld;
    logic                  zero;
    logic                  ovf;
    logic signed [Q_W-1:0] qx;
    logic signed [Q_W-1:0] qy;
  } ppd_div_out_t;

  function automatic ppd_sat32_t clamp32(input logic signed [ACC_W-1:0] v);
    ppd_sat32_t r;
    if (v > S32_MAX) begin
      r.ovf = 1'b1;
      r.val = S32_MAX[Q_W-1:0];
    end else if (v < S32_MIN) begin
      r.ovf = 1'b1;
      r.val = S32_MIN[Q_W-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = v[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic ppd_sat24_t clamp24(input logic signed [ACC_W-1:0] v);
    ppd_sat24_t r;
    if (v > S24_MAX) begin
      r.ovf = 1'b1;
      r.val = S24_MAX[PIX_W-1:0];
    end else if (v < S24_MIN) begin
      r.ovf = 1'b1;
      r.val = S24_MIN[PIX_W-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = v[PIX_W-1:0];
    end
    return r;
  endfunction

  // Applies the quotient sign, or the saturated value when it overflowed.
  function automatic logic signed [Q_W-1:0] sign_q(input logic [QMAG_W-1:0] mag,
                                                   input logic neg, input logic ovf);
    logic signed [Q_W-1:0] m;
    m = $signed({1'b0, mag});
    if (ovf) begin
      return neg ? S32_MIN[Q_W-1:0] : S32_MAX[Q_W-1:0];
    end
    return neg ? -m : m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ppd_if.sv =====
// ----------------------------------------------------------------------------
// Point projector channels
// Valid/ready channels for points, pixels and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppd_point_if;
  import ppd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppd_pixel_if;
  import ppd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_u;
  logic signed [PIX_W-1:0] pixel_v;
  logic                    depth_zero;
  logic                    saturated;
  modport source (output valid, pixel_u, pixel_v, depth_zero, saturated, input ready);
  modport sink (input valid, pixel_u, pixel_v, depth_zero, saturated, output ready);
endinterface

interface ppd_cfg_if;
  import ppd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ppd_div.sv =====
// ----------------------------------------------------------------------------
// ppd_div
// Pipelined restoring divider giving X/Z and Y/Z as saturated Q7.24 values.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ppd_pkg::ppd_div_in_t  din,
  output ppd_pkg::ppd_div_out_t dout
);
  import ppd_pkg::*;

  localparam int Steps = QMAG_W;

  logic [Steps:0]      vld_r;
  logic [CAM_W-1:0]    rx_r [0:Steps];
  logic [CAM_W-1:0]    ry_r [0:Steps];
  logic [CAM_W-1:0]    ad_r [0:Steps];
  logic [QMAG_W-1:0]   dx_r [0:Steps];
  logic [QMAG_W-1:0]   dy_r [0:Steps];
  logic [QMAG_W-1:0]   qx_r [0:Steps];
  logic [QMAG_W-1:0]   qy_r [0:Steps];
  ppd_div_side_t       side_r [0:Steps];
  logic [CAM_W:0]      tx_c [1:Steps];
  logic [CAM_W:0]      ty_c [1:Steps];
  logic [Steps:1]      gex_c;
  logic [Steps:1]      gey_c;
  logic                out_vld_r;
  logic                out_zero_r;
  logic                out_ovf_r;
  logic signed [Q_W-1:0] out_qx_r;
  logic signed [Q_W-1:0] out_qy_r;

  // One quotient bit per stage: shift in the next dividend bit and subtract
  // the divisor when it fits.
  always_comb begin
    for (int k = 1; k <= Steps; k++) begin
      tx_c[k]  = {rx_r[k-1], dx_r[k-1][QMAG_W-1]};
      ty_c[k]  = {ry_r[k-1], dy_r[k-1][QMAG_W-1]};
      gex_c[k] = tx_c[k] >= {1'b0, ad_r[k-1]};
      gey_c[k] = ty_c[k] >= {1'b0, ad_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[Steps-1:0], din.vld};
      out_vld_r <= vld_r[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // The integer part is below 128 exactly when the magnitude is below
      // 128 times the divisor; the top bits then seed the remainder.
      rx_r[0]        <= din.anx >> INT_W;
      ry_r[0]        <= din.any >> INT_W;
      dx_r[0]        <= {din.anx[INT_W-1:0], FRAC_W'(0)};
      dy_r[0]        <= {din.any[INT_W-1:0], FRAC_W'(0)};
      qx_r[0]        <= '0;
      qy_r[0]        <= '0;
      ad_r[0]        <= din.ad;
      side_r[0].zero <= din.zero;
      side_r[0].negx <= din.negx;
      side_r[0].negy <= din.negy;
      side_r[0].ovfx <= {INT_W'(0), din.anx} >= {din.ad, INT_W'(0)};
      side_r[0].ovfy <= {INT_W'(0), din.any} >= {din.ad, INT_W'(0)};
      for (int k = 1; k <= Steps; k++) begin
        rx_r[k]   <= gex_c[k] ? CAM_W'(tx_c[k] - {1'b0, ad_r[k-1]}) : tx_c[k][CAM_W-1:0];
        ry_r[k]   <= gey_c[k] ? CAM_W'(ty_c[k] - {1'b0, ad_r[k-1]}) : ty_c[k][CAM_W-1:0];
        dx_r[k]   <= dx_r[k-1] << 1;
        dy_r[k]   <= dy_r[k-1] << 1;
        qx_r[k]   <= {qx_r[k-1][QMAG_W-2:0], gex_c[k]};
        qy_r[k]   <= {qy_r[k-1][QMAG_W-2:0], gey_c[k]};
        ad_r[k]   <= ad_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      out_zero_r <= side_r[Steps].zero;
      out_ovf_r  <= side_r[Steps].ovfx | side_r[Steps].ovfy;
      out_qx_r   <= sign_q(qx_r[Steps], side_r[Steps].negx, side_r[Steps].ovfx);
      out_qy_r   <= sign_q(qy_r[Steps], side_r[Steps].negy, side_r[Steps].ovfy);
    end
  end

  assign dout.vld  = out_vld_r;
  assign dout.zero = out_zero_r;
  assign dout.ovf  = out_ovf_r;
  assign dout.qx   = out_qx_r;
  assign dout.qy   = out_qy_r;

endmodule

`default_nettype wire

// ===== rtl/point_projection_with_distortion.sv =====
// ----------------------------------------------------------------------------
// point_projection_with_distortion
// Pinhole projector with Brown-Conrady radial and tangential distortion.
// ----------------------------------------------------------------------------
// A point accepted on in_ch passes through 48 register stages before its
// pixel request is valid on out_ch.
// Throughput: one point per cycle; every stage advances together and holds
// while the output register is full and not taken.
// Reset (synchronous, rst_n low) empties the pipeline and loads the identity
// rotation, unit focal lengths and zero for every other register.
`default_nettype none

module point_projection_with_distortion (
  input logic        clk,
  input logic        rst_n,
  ppd_point_if.sink  in_ch,
  ppd_pixel_if.source out_ch,
  ppd_cfg_if.sink    cfg_ch
);
  import ppd_pkg::*;

  localparam int PST = 13;

  // Configuration registers. Software must write them only while the block is
  // idle; the block does not enforce this, and the pipeline reads them directly.
  logic [ROW_W-1:0]  rot0_r, rot1_r, rot2_r;
  logic [TRN_W-1:0]  trn_r;
  logic [RADC_W-1:0] radc_r;
  logic [TANC_W-1:0] tanc_r;
  logic [ROW_W-1:0]  foc_r;
  logic [ROW_W-1:0]  ppt_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot0_r <= ROT0_RST;
      rot1_r <= ROT1_RST;
      rot2_r <= ROT2_RST;
      trn_r  <= '0;
      radc_r <= '0;
      tanc_r <= '0;
      foc_r  <= FOCAL_RST;
      ppt_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (ppd_reg_t'(cfg_ch.index))
        REG_ROT0:    rot0_r <= cfg_ch.data[ROW_W-1:0];
        REG_ROT1:    rot1_r <= cfg_ch.data[ROW_W-1:0];
        REG_ROT2:    rot2_r <= cfg_ch.data[ROW_W-1:0];
        REG_TRANS:   trn_r  <= cfg_ch.data[TRN_W-1:0];
        REG_RADIAL:  radc_r <= cfg_ch.data[RADC_W-1:0];
        REG_TANGENT: tanc_r <= cfg_ch.data[TANC_W-1:0];
        REG_FOCAL:   foc_r  <= cfg_ch.data[ROW_W-1:0];
        REG_PPOINT:  ppt_r  <= cfg_ch.data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient fields.
  logic signed [K_W-1:0] k1, k2, k3, p1, p2;
  logic signed [F_W:0]   fxs, fys;
  logic signed [F_W-1:0] cx, cy;

  assign k1  = $signed(radc_r[K_W-1:0]);
  assign k2  = $signed(radc_r[2*K_W-1:K_W]);
  assign k3  = $signed(radc_r[3*K_W-1:2*K_W]);
  assign p1  = $signed(tanc_r[K_W-1:0]);
  assign p2  = $signed(tanc_r[2*K_W-1:K_W]);
  assign fxs = $signed({1'b0, foc_r[F_W-1:0]});
  assign fys = $signed({1'b0, foc_r[2*F_W-1:F_W]});
  assign cx  = $signed(ppt_r[F_W-1:0]);
  assign cy  = $signed(ppt_r[2*F_W-1:F_W]);

  // The whole pipeline moves as one; the output register is the only place
  // where a result waits, so a new point enters whenever it can move.
  logic out_vld_r;
  logic adv;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Camera frame: nine products, then the row sums plus translation.
  localparam int MP_W = ROT_W + PT_W;
  logic signed [MP_W-1:0]  m_r [0:2][0:2];
  logic [ROW_W-1:0]        rows [0:2];
  logic signed [PT_W-1:0]  pts [0:2];
  logic signed [CAM_W-1:0] cam_c [0:2];
  logic                    c1_vld_r;
  ppd_div_in_t             div_in_r;
  ppd_div_out_t            div_out;

  assign rows[0] = rot0_r;
  assign rows[1] = rot1_r;
  assign rows[2] = rot2_r;
  assign pts[0]  = in_ch.point_x;
  assign pts[1]  = in_ch.point_y;
  assign pts[2]  = in_ch.point_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cam_c[i] = CAM_W'(m_r[i][0]) + CAM_W'(m_r[i][1]) + CAM_W'(m_r[i][2])
               + CAM_W'($signed({trn_r[i*TR_W +: TR_W], TR_SHIFT'(0)}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r     <= 1'b0;
      div_in_r.vld <= 1'b0;
    end else if (adv) begin
      c1_vld_r     <= in_ch.valid;
      div_in_r.vld <= c1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m_r[i][j] <= $signed(rows[i][j*ROT_W +: ROT_W]) * pts[j];
        end
      end
      // Sign and magnitude split for the divider; the quotient sign is the
      // exclusive-or of the operand signs.
      div_in_r.zero <= cam_c[2] == '0;
      div_in_r.negx <= cam_c[0][CAM_W-1] ^ cam_c[2][CAM_W-1];
      div_in_r.negy <= cam_c[1][CAM_W-1] ^ cam_c[2][CAM_W-1];
      div_in_r.anx  <= cam_c[0][CAM_W-1] ? CAM_W'(-cam_c[0]) : CAM_W'(cam_c[0]);
      div_in_r.any  <= cam_c[1][CAM_W-1] ? CAM_W'(-cam_c[1]) : CAM_W'(cam_c[1]);
      div_in_r.ad   <= cam_c[2][CAM_W-1] ? CAM_W'(-cam_c[2]) : CAM_W'(cam_c[2]);
    end
  end

  ppd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (adv),
    .din  (div_in_r),
    .dout (div_out)
  );

  // Distortion pipeline. Stage n registers carry the suffix n; x and y, the
  // zero-depth mark and the running saturation flag travel with each point.
  logic [PST-1:1] pv_r;
  logic [PST-1:1] z_r;
  logic [PST-1:1] s_r;
  logic signed [Q_W-1:0]    x_r [1:9];
  logic signed [Q_W-1:0]    y_r [1:9];
  logic signed [PROD_W-1:0] pxx1_r, pyy1_r, pxy1_r;
  logic signed [Q_W-1:0]    xx2_r, yy2_r, xy2_r;
  logic signed [Q_W-1:0]    xx3_r, yy3_r, xy3_r, r2_3_r;
  logic signed [Q_W-1:0]    xy4_r, r2_4_r, tx4_r, ty4_r;
  logic signed [PROD_W-1:0] pr4_4_r;
  logic signed [Q_W-1:0]    r2_5_r, r4_5_r;
  logic signed [KP_W-1:0]   k1r2_5_r, a5_r, b5_r, c5_r, d5_r;
  logic signed [PROD_W-1:0] pr6_6_r;
  logic signed [KP_W-1:0]   k1r2_6_r, k2r4_6_r;
  logic signed [TG_W-1:0]   tgx6_r, tgy6_r;
  logic signed [Q_W-1:0]    r6_7_r;
  logic signed [TG_W-2:0]   rs12_7_r, rs12_8_r;
  logic signed [TS_W-1:0]   tsx_r [7:10];
  logic signed [TS_W-1:0]   tsy_r [7:10];
  logic signed [KP_W-1:0]   k3r6_8_r;
  logic signed [Q_W-1:0]    rad9_r;
  logic signed [PROD_W-1:0] pxr10_r, pyr10_r;
  logic signed [Q_W-1:0]    xd11_r, yd11_r;
  logic signed [FP_W-1:0]   pu12_r, pv12_r;
  logic signed [PIX_W-1:0]  out_u_r, out_v_r;
  logic                     out_zero_r, out_sat_r;

  ppd_sat32_t c_xx, c_yy, c_xy, c_r2, c_tx, c_ty, c_r4, c_r6, c_rad, c_xd, c_yd;
  ppd_sat24_t c_u, c_v;

  always_comb begin
    c_xx  = clamp32(ACC_W'(pxx1_r >>> FRAC_W));
    c_yy  = clamp32(ACC_W'(pyy1_r >>> FRAC_W));
    c_xy  = clamp32(ACC_W'(pxy1_r >>> FRAC_W));
    c_r2  = clamp32(ACC_W'(xx2_r) + ACC_W'(yy2_r));
    c_tx  = clamp32(ACC_W'(r2_3_r) + (ACC_W'(xx3_r) <<< 1));
    c_ty  = clamp32(ACC_W'(r2_3_r) + (ACC_W'(yy3_r) <<< 1));
    c_r4  = clamp32(ACC_W'(pr4_4_r >>> FRAC_W));
    c_r6  = clamp32(ACC_W'(pr6_6_r >>> FRAC_W));
    c_rad = clamp32(((ACC_W'(rs12_8_r) + ACC_W'(k3r6_8_r)) >>> KF_W) + NORM_ONE);
    c_xd  = clamp32((ACC_W'(pxr10_r) >>> FRAC_W) + ACC_W'(tsx_r[10]));
    c_yd  = clamp32((ACC_W'(pyr10_r) >>> FRAC_W) + ACC_W'(tsy_r[10]));
    c_u   = clamp24((ACC_W'(pu12_r) >>> FRAC_W) + ACC_W'(cx));
    c_v   = clamp24((ACC_W'(pv12_r) >>> FRAC_W) + ACC_W'(cy));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      pv_r      <= {pv_r[PST-2:1], div_out.vld};
      out_vld_r <= pv_r[PST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: squares and cross product of the normalized point.
      x_r[1] <= div_out.qx;
      y_r[1] <= div_out.qy;
      z_r[1] <= div_out.zero;
      s_r[1] <= div_out.ovf;
      pxx1_r <= div_out.qx * div_out.qx;
      pyy1_r <= div_out.qy * div_out.qy;
      pxy1_r <= div_out.qx * div_out.qy;
      for (int n = 2; n <= 9; n++) begin
        x_r[n] <= x_r[n-1];
        y_r[n] <= y_r[n-1];
      end
      for (int n = 2; n < PST; n++) begin
        z_r[n] <= z_r[n-1];
      end
      // Stage 2: scale and clamp.
      xx2_r  <= c_xx.val;
      yy2_r  <= c_yy.val;
      xy2_r  <= c_xy.val;
      s_r[2] <= s_r[1] | c_xx.ovf | c_yy.ovf | c_xy.ovf;
      // Stage 3: squared radius.
      xx3_r  <= xx2_r;
      yy3_r  <= yy2_r;
      xy3_r  <= xy2_r;
      r2_3_r <= c_r2.val;
      s_r[3] <= s_r[2] | c_r2.ovf;
      // Stage 4: r2 squared and the tangential radius terms.
      xy4_r   <= xy3_r;
      r2_4_r  <= r2_3_r;
      pr4_4_r <= r2_3_r * r2_3_r;
      tx4_r   <= c_tx.val;
      ty4_r   <= c_ty.val;
      s_r[4]  <= s_r[3] | c_tx.ovf | c_ty.ovf;
      // Stage 5: r4 and the coefficient products that are ready.
      r2_5_r   <= r2_4_r;
      r4_5_r   <= c_r4.val;
      k1r2_5_r <= k1 * r2_4_r;
      a5_r     <= p1 * xy4_r;
      b5_r     <= p2 * tx4_r;
      c5_r     <= p2 * xy4_r;
      d5_r     <= p1 * ty4_r;
      s_r[5]   <= s_r[4] | c_r4.ovf;
      // Stage 6: r6 product, k2 term and the tangential sums.
      pr6_6_r  <= r4_5_r * r2_5_r;
      k2r4_6_r <= k2 * r4_5_r;
      k1r2_6_r <= k1r2_5_r;
      tgx6_r   <= (TG_W'(a5_r) <<< 1) + TG_W'(b5_r);
      tgy6_r   <= (TG_W'(c5_r) <<< 1) + TG_W'(d5_r);
      s_r[6]   <= s_r[5];
      // Stage 7: r6 and partial radial sum.
      r6_7_r   <= c_r6.val;
      rs12_7_r <= (TG_W-1)'(k1r2_6_r) + (TG_W-1)'(k2r4_6_r);
      tsx_r[7] <= TS_W'(tgx6_r >>> KF_W);
      tsy_r[7] <= TS_W'(tgy6_r >>> KF_W);
      s_r[7]   <= s_r[6] | c_r6.ovf;
      // Stage 8: k3 term.
      k3r6_8_r <= k3 * r6_7_r;
      rs12_8_r <= rs12_7_r;
      for (int n = 8; n <= 10; n++) begin
        tsx_r[n] <= tsx_r[n-1];
        tsy_r[n] <= tsy_r[n-1];
      end
      s_r[8]   <= s_r[7];
      // Stage 9: radial gain.
      rad9_r   <= c_rad.val;
      s_r[9]   <= s_r[8] | c_rad.ovf;
      // Stage 10: apply the radial gain.
      pxr10_r  <= x_r[9] * rad9_r;
      pyr10_r  <= y_r[9] * rad9_r;
      s_r[10]  <= s_r[9];
      // Stage 11: distorted normalized point.
      xd11_r   <= c_xd.val;
      yd11_r   <= c_yd.val;
      s_r[11]  <= s_r[10] | c_xd.ovf | c_yd.ovf;
      // Stage 12: focal scaling.
      pu12_r   <= fxs * xd11_r;
      pv12_r   <= fys * yd11_r;
      s_r[12]  <= s_r[11];
      // Output register: principal point, final clamp, zero-depth override.
      // The zero mark and flag come from stage 12, next to the scaled point.
      if (z_r[PST-1]) begin
        out_u_r    <= '0;
        out_v_r    <= '0;
        out_zero_r <= 1'b1;
        out_sat_r  <= 1'b0;
      end else begin
        out_u_r    <= c_u.val;
        out_v_r    <= c_v.val;
        out_zero_r <= 1'b0;
        out_sat_r  <= s_r[PST-1] | c_u.ovf | c_v.ovf;
      end
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.pixel_u    = out_u_r;
  assign out_ch.pixel_v    = out_v_r;
  assign out_ch.depth_zero = out_zero_r;
  assign out_ch.saturated  = out_sat_r;

endmodule

`default_nettype wire

// ===== rtl/ppd_chk.sv =====
// ----------------------------------------------------------------------------
// ppd_chk
// Port-level checks of the point projector, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ppd_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [ppd_pkg::PIX_W-1:0] pixel_u,
  input logic signed [ppd_pkg::PIX_W-1:0] pixel_v,
  input logic                            depth_zero,
  input logic                            saturated
);
  import ppd_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && in_ready;

  `PPD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid right after reset")
  `PPD_ASSERT(a_ready_free, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")
  `PPD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `PPD_ASSERT(a_zero_pix, clk, rst_n, out_valid && depth_zero |-> pixel_u == '0 && pixel_v == '0 && !saturated, "zero depth result not cleared")
  `PPD_ASSERT(a_stall_in, clk, rst_n, out_valid && !out_ready |-> !in_seen, "point taken while stalled")

endmodule

bind point_projection_with_distortion ppd_chk u_ppd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pixel_u   (out_ch.pixel_u),
  .pixel_v   (out_ch.pixel_v),
  .depth_zero(out_ch.depth_zero),
  .saturated (out_ch.saturated)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Point projector testbench
// Sends 3-D points through the projector under several camera settings and
// compares every pixel request with a typed result or a fixed-point projection computed here.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ppd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DRAIN = 60;     // a little over the pipeline depth
  localparam int STALL_LIMIT = 20000; // cycles without any request accepted
  localparam int PHASES = 8;

  typedef struct {
    logic signed [PIX_W-1:0] u;
    logic signed [PIX_W-1:0] v;
    logic                    dz;
    logic                    sat;
  } pixel_t;

  // One directed point; the typed result is used only where check is set.
  typedef struct {
    int x, y, z;
    bit check;
    int u, v;
    bit dz, sat;
  } point_row_t;

  logic clk;
  logic rst_n;

  ppd_point_if in_ch();
  ppd_pixel_if out_ch();
  ppd_cfg_if   cfg_ch();

  point_projection_with_distortion i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register image that the projection below works from.
  logic [63:0] cam_regs [8];
  pixel_t      pending_pixels [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          burst;   // no idling on either side while set
  int          stall_left = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Projection arithmetic. Right shifts round toward minus infinity.
  // ---------------------------------------------------------------------------
  function automatic longint sub_field(input logic [63:0] r, input int pos, input int bits);
    logic [63:0] t;
    t = r << (64 - pos - bits);
    return $signed(t) >>> (64 - bits);
  endfunction

  function automatic longint clip(input longint val, input longint lo, input longint hi,
                                  inout bit ovf);
    if (val < lo) begin
      ovf = 1'b1;
      return lo;
    end
    if (val > hi) begin
      ovf = 1'b1;
      return hi;
    end
    return val;
  endfunction

  // Quotient in Q7.24: magnitude truncated, then signed, saturated at 128.
  function automatic longint ratio_q24(input longint num, input longint den, inout bit ovf);
    bit neg;
    longint unsigned an, ad, rem, q;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = an / ad;
    rem = an % ad;
    if (q >= 128) begin
      ovf = 1'b1;
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    for (int i = 0; i < 24; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= ad) begin
        rem = rem - ad;
        q = q | 1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic pixel_t project_point(input longint px, input longint py, input longint pz);
    pixel_t r;
    bit f;
    longint cam [3];
    longint x, y, xx, yy, xy, r2, r4, r6, rad, tx, ty, xd, yd, fx, fy;
    longint k1, k2, k3, p1, p2, lo, hi;
    f = 1'b0;
    lo = -64'sd2147483648;
    hi = 64'sd2147483647;
    for (int i = 0; i < 3; i++) begin
      cam[i] = sub_field(cam_regs[REG_ROT0 + i], 0, 16) * px
             + sub_field(cam_regs[REG_ROT0 + i], 16, 16) * py
             + sub_field(cam_regs[REG_ROT0 + i], 32, 16) * pz
             + sub_field(cam_regs[REG_TRANS], 21 * i, 21) * 262144;
    end
    if (cam[2] == 0) begin
      r.u = '0;
      r.v = '0;
      r.dz = 1'b1;
      r.sat = 1'b0;
      return r;
    end
    x = ratio_q24(cam[0], cam[2], f);
    y = ratio_q24(cam[1], cam[2], f);
    xx = clip((x * x) >>> 24, lo, hi, f);
    yy = clip((y * y) >>> 24, lo, hi, f);
    xy = clip((x * y) >>> 24, lo, hi, f);
    r2 = clip(xx + yy, lo, hi, f);
    r4 = clip((r2 * r2) >>> 24, lo, hi, f);
    r6 = clip((r4 * r2) >>> 24, lo, hi, f);
    k1 = sub_field(cam_regs[REG_RADIAL], 0, 20);
    k2 = sub_field(cam_regs[REG_RADIAL], 20, 20);
    k3 = sub_field(cam_regs[REG_RADIAL], 40, 20);
    p1 = sub_field(cam_regs[REG_TANGENT], 0, 20);
    p2 = sub_field(cam_regs[REG_TANGENT], 20, 20);
    rad = clip(((k1 * r2 + k2 * r4 + k3 * r6) >>> 16) + 64'sd16777216, lo, hi, f);
    tx = clip(r2 + 2 * xx, lo, hi, f);
    ty = clip(r2 + 2 * yy, lo, hi, f);
    xd = clip(((x * rad) >>> 24) + ((2 * p1 * xy + p2 * tx) >>> 16), lo, hi, f);
    yd = clip(((y * rad) >>> 24) + ((2 * p2 * xy + p1 * ty) >>> 16), lo, hi, f);
    fx = longint'({40'd0, cam_regs[REG_FOCAL][23:0]});
    fy = longint'({40'd0, cam_regs[REG_FOCAL][47:24]});
    r.u = PIX_W'(clip(((fx * xd) >>> 24) + sub_field(cam_regs[REG_PPOINT], 0, 24),
                      -64'sd8388608, 64'sd8388607, f));
    r.v = PIX_W'(clip(((fy * yd) >>> 24) + sub_field(cam_regs[REG_PPOINT], 24, 24),
                      -64'sd8388608, 64'sd8388607, f));
    r.dz = 1'b0;
    r.sat = f;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request pacing: mostly back to back, some short gaps, a few long ones.
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The pixel side stalls on its own schedule; long stalls stay rare.
  always @(posedge clk) begin
    if (!rst_n || burst) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:2]: begin
          out_ch.ready <= 1'b0;
          stall_left <= $urandom_range(10, 40);
        end
        [3:22]: begin
          out_ch.ready <= 1'b0;
          stall_left <= $urandom_range(0, 2);
        end
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  // Every accepted pixel request is compared with the oldest pending projection.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel u=%0d v=%0d dz=%0b sat=%0b", out_ch.pixel_u,
                   out_ch.pixel_v, out_ch.depth_zero, out_ch.saturated);
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.pixel_u !== want.u || out_ch.pixel_v !== want.v ||
            out_ch.depth_zero !== want.dz || out_ch.saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected u=%0d v=%0d dz=%0b sat=%0b, got u=%0d v=%0d dz=%0b sat=%0b",
                     want.u, want.v, want.dz, want.sat, out_ch.pixel_u, out_ch.pixel_v,
                     out_ch.depth_zero, out_ch.saturated);
        end
      end
    end
  end

  // The watchdog ends a run that stops moving requests on every channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Waits until the pipeline is empty and then lets it settle.
  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Register writes happen only with nothing in flight, so the local image is
  // updated as soon as the write request is taken. Valid stays high across
  // back-to-back writes; the caller lowers it after the last one.
  task automatic write_reg(input ppd_reg_t idx, input logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ROT0, REG_ROT1, REG_ROT2, REG_FOCAL, REG_PPOINT: cam_regs[idx] = 64'(data[47:0]);
      REG_TRANS: cam_regs[idx] = 64'(data[62:0]);
      REG_RADIAL: cam_regs[idx] = 64'(data[59:0]);
      default: cam_regs[idx] = 64'(data[39:0]);
    endcase
  endtask

  // Sends one point; valid stays high across back-to-back requests.
  task automatic send_point(input int x, input int y, input int z, input bit typed,
                            input pixel_t typed_pix);
    int n;
    pixel_t want;
    n = gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_x <= x[PT_W-1:0];
    in_ch.point_y <= y[PT_W-1:0];
    in_ch.point_z <= z[PT_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    // The block sees only the low coordinate bits, taken as signed.
    want = typed ? typed_pix : project_point(longint'($signed(x[PT_W-1:0])),
                                             longint'($signed(y[PT_W-1:0])),
                                             longint'($signed(z[PT_W-1:0])));
    pending_pixels.insert(pending_pixels.size(), want);
  endtask

  function automatic int rnd_span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // A rotation row with the given diagonal slot near one and small cross terms.
  function automatic logic [63:0] near_rot_row(input int diag);
    logic [15:0] e [3];
    for (int i = 0; i < 3; i++)
      e[i] = (i == diag) ? 16'(rnd_span(14000, 16384)) : 16'(rnd_span(-3000, 3000));
    return {16'd0, e[2], e[1], e[0]};
  endfunction

  // Loads the register set of one phase. Phase zero keeps the reset values.
  task automatic load_phase(input int phase);
    logic [63:0] full_rand;
    case (phase)
      1: begin
        // Everything zero: no rotation and no shift, so every depth is zero.
        for (int r = REG_ROT0; r <= REG_PPOINT; r++) write_reg(ppd_reg_t'(r), 64'd0);
      end
      2: begin
        // Every bit set, extra bits above each register's width included.
        for (int r = REG_ROT0; r <= REG_PPOINT; r++) write_reg(ppd_reg_t'(r), '1);
      end
      5: begin
        for (int r = REG_ROT0; r <= REG_PPOINT; r++) begin
          full_rand = {$urandom, $urandom};
          write_reg(ppd_reg_t'(r), full_rand);
        end
      end
      7: begin
        // Extremes: widest focal lengths, opposite corner principal point,
        // most negative and most positive coefficients.
        write_reg(REG_ROT0, {16'd0, 16'h0000, 16'h0000, 16'h7fff});
        write_reg(REG_ROT1, {16'd0, 16'h0000, 16'h8000, 16'h0000});
        write_reg(REG_ROT2, {16'd0, 16'h7fff, 16'h0000, 16'h0000});
        write_reg(REG_TRANS, {1'b0, 21'h0fffff, 21'h100000, 21'h0fffff});
        write_reg(REG_RADIAL, {4'd0, 20'h80000, 20'h7ffff, 20'h80000});
        write_reg(REG_TANGENT, {24'd0, 20'h7ffff, 20'h80000});
        write_reg(REG_FOCAL, {16'd0, 24'hffffff, 24'hffffff});
        write_reg(REG_PPOINT, {16'd0, 24'h7fffff, 24'h800000});
      end
      default: begin
        // A plausible camera; phase four adds strong distortion.
        write_reg(REG_ROT0, near_rot_row(0));
        write_reg(REG_ROT1, near_rot_row(1));
        write_reg(REG_ROT2, near_rot_row(2));
        write_reg(REG_TRANS, {1'b0, 21'(rnd_span(0, 16000)), 21'(rnd_span(-2000, 2000)),
                              21'(rnd_span(-2000, 2000))});
        if (phase == 4) begin
          write_reg(REG_RADIAL, {4'd0, 20'(rnd_span(-300000, 300000)),
                                 20'(rnd_span(-300000, 300000)), 20'(rnd_span(-300000, 300000))});
          write_reg(REG_TANGENT, {24'd0, 20'(rnd_span(-100000, 100000)),
                                  20'(rnd_span(-100000, 100000))});
        end else begin
          write_reg(REG_RADIAL, {4'd0, 20'(rnd_span(-5000, 5000)), 20'(rnd_span(-10000, 10000)),
                                 20'(rnd_span(-20000, 20000))});
          write_reg(REG_TANGENT, {24'd0, 20'(rnd_span(-1000, 1000)),
                                  20'(rnd_span(-1000, 1000))});
        end
        write_reg(REG_FOCAL, {16'd0, 24'(rnd_span(100000, 300000)),
                              24'(rnd_span(100000, 300000))});
        write_reg(REG_PPOINT, {16'd0, 24'(rnd_span(50000, 100000)),
                               24'(rnd_span(50000, 150000))});
      end
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed points, then one random stretch per phase.
  // ---------------------------------------------------------------------------
  initial begin
    point_row_t directed [15];
    pixel_t typed_pix;
    int x, y, z, count;

    // Points taken against the reset camera: identity rotation, unit focal
    // lengths, no shift, no distortion. With that camera u = x/z and v = y/z.
    directed = '{
      '{256, 0, 256, 1, 256, 0, 0, 0},
      '{0, 256, 256, 1, 0, 256, 0, 0},
      '{0, 0, 256, 1, 0, 0, 0, 0},
      // Normalized coordinates of two push r6 past the 32-bit range, so the flag is set.
      '{512, -512, 256, 1, 512, -512, 0, 1},
      // Negative depth projects through without any sign fix-up.
      '{256, 256, -256, 1, -256, -256, 0, 0},
      // Zero depth gives a zero pixel and the depth flag, whatever x and y are.
      '{5, 7, 0, 1, 0, 0, 1, 0},
      '{-8388608, -8388608, 0, 1, 0, 0, 1, 0},
      '{8388607, 8388607, 0, 1, 0, 0, 1, 0},
      '{8388607, 8388607, 8388607, 1, 256, 256, 0, 0},
      '{-8388608, -8388608, -8388608, 1, 256, 256, 0, 0},
      // Huge ratios saturate the normalized coordinates in the first two rows.
      '{8388607, 0, 1, 0, 0, 0, 0, 0},
      '{-8388608, 8388607, 1, 0, 0, 0, 0, 0},
      '{8388607, -8388608, -8388608, 0, 0, 0, 0, 0},
      '{1, 1, 8388607, 0, 0, 0, 0, 0},
      '{100, -300, 12345, 0, 0, 0, 0, 0}
    };

    rst_n = 1'b0;
    burst = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ROT0;
    cfg_ch.data = '0;
    cam_regs[REG_ROT0] = 64'(ROT0_RST);
    cam_regs[REG_ROT1] = 64'(ROT1_RST);
    cam_regs[REG_ROT2] = 64'(ROT2_RST);
    cam_regs[REG_TRANS] = '0;
    cam_regs[REG_RADIAL] = '0;
    cam_regs[REG_TANGENT] = '0;
    cam_regs[REG_FOCAL] = 64'(FOCAL_RST);
    cam_regs[REG_PPOINT] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      typed_pix.u = PIX_W'(directed[i].u);
      typed_pix.v = PIX_W'(directed[i].v);
      typed_pix.dz = directed[i].dz;
      typed_pix.sat = directed[i].sat;
      send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].check, typed_pix);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        // Lower valid before the pipeline drains so that no point slips in.
        in_ch.valid <= 1'b0;
        wait_drained();
        load_phase(phase);
      end
      count = (phase == 1) ? 40 : 170;
      for (int n = 0; n < count; n++) begin
        // Alternate paced stretches with stretches that run flat out.
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 15) begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
        end else begin
          x = rnd_span(-51200, 51200);
          y = rnd_span(-51200, 51200);
          z = rnd_span(76800, 768000);
          if ($urandom_range(0, 49) == 0) z = 0;
        end
        send_point(x, y, z, 1'b0, typed_pix);
      end
    end
    in_ch.valid <= 1'b0;
    burst = 1'b0;
    wait_drained();

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
